// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL files.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every enabled clock edge.
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Expression must never be true on an enabled clock edge.
`define ASSERT_NOT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

// ----- rtl/nwl_pkg.sv -----
// ---------------------------------------------------------------------------
// nwl_pkg
// Types, widths and codes for the nearest waypoint look-ahead unit.
// ---------------------------------------------------------------------------
package nwl_pkg;

    localparam int XW      = 24;          // coordinate width
    localparam int HW      = 16;          // heading width
    localparam int RW      = 23;          // search radius width
    localparam int RSQW    = 2 * RW;      // squared radius width
    localparam int IXW     = 12;          // reported index width
    localparam int AW      = XW + 1;      // absolute difference width
    localparam int DW      = 2 * AW + 1;  // squared distance sum width
    localparam int ENTRY_W = 2 * XW + HW; // one route entry {x, y, heading}

    localparam int ROUTE_DEPTH_DEF = 4096;
    localparam int WINDOW_DEF      = 10;

    localparam logic [RW-1:0]   RADIUS_RST = RW'(300000);
    localparam logic [RSQW-1:0] RAD_SQ_RST = RSQW'(64'd90000000000);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_MISS
    } t_state;

    typedef struct packed {
        logic [1:0]           op;
        logic signed [XW-1:0] coord_x;
        logic signed [XW-1:0] coord_y;
        logic signed [HW-1:0] heading_in;
    } t_in_beat;

    typedef struct packed {
        logic                 found;
        logic [IXW-1:0]       ref_index;
        logic signed [XW-1:0] out_x;
        logic signed [XW-1:0] out_y;
        logic signed [HW-1:0] out_heading;
        logic                 padded;
        logic                 last;
    } t_out_beat;

endpackage

// ----- rtl/nwl_ram.sv -----
// ---------------------------------------------------------------------------
// nwl_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. Read data holds while no read is enabled.
// ---------------------------------------------------------------------------
module nwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/nwl_dist.sv -----
// ---------------------------------------------------------------------------
// nwl_dist
// Three-stage squared distance pipeline: absolute differences, squares,
// sum. Carries the route index of each point alongside.
// ---------------------------------------------------------------------------
module nwl_dist #(
    parameter int IW = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [IW-1:0]                 i_idx,
    input  logic signed [nwl_pkg::XW-1:0] i_px,
    input  logic signed [nwl_pkg::XW-1:0] i_py,
    input  logic signed [nwl_pkg::XW-1:0] i_qx,
    input  logic signed [nwl_pkg::XW-1:0] i_qy,
    output logic                          o_vld,
    output logic [IW-1:0]                 o_idx,
    output logic [nwl_pkg::DW-1:0]        o_dist,
    output logic                          o_busy
);
    import nwl_pkg::*;

    logic signed [AW-1:0] w_dx;
    logic signed [AW-1:0] w_dy;
    logic [AW-1:0]        w_ax;
    logic [AW-1:0]        w_ay;

    logic [2:0]           r_v;
    logic [IW-1:0]        r_idx [3];
    logic [AW-1:0]        r_ax;
    logic [AW-1:0]        r_ay;
    logic [2*AW-1:0]      r_sx;
    logic [2*AW-1:0]      r_sy;
    logic [DW-1:0]        r_d;

    always_comb begin
        w_dx = {i_px[XW-1], i_px} - {i_qx[XW-1], i_qx};
        w_dy = {i_py[XW-1], i_py} - {i_qy[XW-1], i_qy};
        w_ax = w_dx[AW-1] ? AW'(-w_dx) : AW'(w_dx);
        w_ay = w_dy[AW-1] ? AW'(-w_dy) : AW'(w_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx[0] <= i_idx;
        r_idx[1] <= r_idx[0];
        r_idx[2] <= r_idx[1];
        r_ax     <= w_ax;
        r_ay     <= w_ay;
        r_sx     <= (2*AW)'(r_ax) * (2*AW)'(r_ax);
        r_sy     <= (2*AW)'(r_ay) * (2*AW)'(r_ay);
        r_d      <= DW'(r_sx) + DW'(r_sy);
    end

    assign o_vld  = r_v[2];
    assign o_idx  = r_idx[2];
    assign o_dist = r_d;
    assign o_busy = |r_v;

endmodule

// ----- rtl/nearest_waypoint_lookahead_unit.sv -----
// Clear and append are taken while idle. A query is accepted, then scans the
// route through one RAM read port, one point per cycle, then emits its results:
// on a hit, WINDOW results, each by a RAM read and then an output load; else the
// single not-found result. Any output stall holds the emit. Input stalls meanwhile.
// Reset empties the route and sets the radius to 300000 mm; RAM is not cleared.
// ---------------------------------------------------------------------------
// nearest_waypoint_lookahead_unit
// Route table in RAM with nearest-point search under a radius limit and a
// fixed look-ahead window of emitted waypoints.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_waypoint_lookahead_unit #(
    parameter int ROUTE_DEPTH = nwl_pkg::ROUTE_DEPTH_DEF,
    parameter int WINDOW      = nwl_pkg::WINDOW_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  nwl_pkg::t_in_beat      i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output nwl_pkg::t_out_beat     o_out_data,
    input  logic                   i_cfg_we,
    input  logic [nwl_pkg::RW-1:0] i_cfg_wdata
);
    import nwl_pkg::*;

    localparam int IW = $clog2(ROUTE_DEPTH);
    localparam int LW = $clog2(ROUTE_DEPTH + 1);
    localparam int KW = $clog2(WINDOW + 1);
    localparam int PW = LW + KW;
    localparam int SW = IW + IXW;

    t_state               r_state;
    t_state               n_state;
    logic [LW-1:0]        r_len;
    logic [RW-1:0]        r_radius;
    logic [RSQW-1:0]      r_rad_sq;
    logic signed [XW-1:0] r_qx;
    logic signed [XW-1:0] r_qy;
    logic [LW-1:0]        r_issue;
    logic                 r_rd_vld;
    logic [IW-1:0]        r_rd_idx;
    logic [DW-1:0]        r_best;
    logic                 r_hit;
    logic [IW-1:0]        r_sel;
    logic [KW-1:0]        r_k;
    logic                 r_pad;
    logic                 r_out_vld;
    t_out_beat            r_out;

    logic                 w_accept;
    logic                 w_append;
    logic                 ram_we;
    logic                 ram_re;
    logic [IW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic                 w_scan_rd;
    logic                 w_scan_done;
    logic                 w_load_hit;
    logic                 w_load_miss;
    logic                 w_out_free;
    logic                 w_last_k;
    logic [PW-1:0]        w_pos;
    logic                 w_pad;
    logic [LW-1:0]        w_len_m1;
    logic [IW-1:0]        w_emit_addr;
    logic [SW-1:0]        w_sel_ext;
    logic [DW-1:0]        w_bound;
    t_out_beat            w_miss_beat;

    logic                 dist_vld;
    logic [IW-1:0]        dist_idx;
    logic [DW-1:0]        dist_val;
    logic                 dist_busy;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_append   = w_accept && (i_in_data.op == OP_APPEND) && (r_len < LW'(ROUTE_DEPTH));
    assign ram_we     = w_append;
    assign ram_wdata  = {i_in_data.coord_x, i_in_data.coord_y, i_in_data.heading_in};
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_last_k   = (r_k == KW'(WINDOW - 1));

    // window position, clamped to the last route point past the end
    always_comb begin
        w_pos       = PW'(r_sel) + PW'(r_k);
        w_pad       = (w_pos >= PW'(r_len));
        w_len_m1    = r_len - LW'(1);
        w_emit_addr = w_pad ? w_len_m1[IW-1:0] : w_pos[IW-1:0];
        w_sel_ext   = SW'(r_sel);
        w_bound     = r_hit ? r_best : DW'(r_rad_sq);
    end

    always_comb begin
        w_miss_beat      = '0;
        w_miss_beat.last = 1'b1;
    end

    assign w_scan_done = (r_issue == r_len) && !r_rd_vld && !dist_busy;

    nwl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROUTE_DEPTH)
    ) u_route_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_len[IW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    nwl_dist #(
        .IW (IW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld),
        .i_idx   (r_rd_idx),
        .i_px    (ram_rdata[ENTRY_W-1 -: XW]),
        .i_py    (ram_rdata[HW +: XW]),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_vld   (dist_vld),
        .o_idx   (dist_idx),
        .o_dist  (dist_val),
        .o_busy  (dist_busy)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_in_data.op == OP_QUERY)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = r_hit ? ST_EMIT_RD : ST_MISS;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (w_out_free) begin
                    n_state = w_last_k ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_MISS: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall  = 1'b1;
        ram_re      = 1'b0;
        ram_raddr   = r_issue[IW-1:0];
        w_scan_rd   = 1'b0;
        w_load_hit  = 1'b0;
        w_load_miss = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_SCAN: begin
                w_scan_rd = (r_issue < r_len);
                ram_re    = w_scan_rd;
            end
            ST_EMIT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = w_emit_addr;
            end
            ST_EMIT_WR: begin
                w_load_hit = w_out_free;
            end
            ST_MISS: begin
                w_load_miss = w_out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= '0;
            r_radius  <= RADIUS_RST;
            r_rad_sq  <= RAD_SQ_RST;
            r_issue   <= '0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_k       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rad_sq <= RSQW'(r_radius) * RSQW'(r_radius);
            r_rd_vld <= w_scan_rd;
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (w_accept && (i_in_data.op == OP_CLEAR)) begin
                r_len <= '0;
            end else if (w_append) begin
                r_len <= r_len + LW'(1);
            end
            if (w_accept) begin
                r_issue <= '0;
                r_hit   <= 1'b0;
            end else begin
                if (w_scan_rd) begin
                    r_issue <= r_issue + LW'(1);
                end
                if (dist_vld && (dist_val < w_bound)) begin
                    r_hit <= 1'b1;
                end
            end
            if (r_state == ST_SCAN) begin
                r_k <= '0;
            end else if (w_load_hit) begin
                r_k <= r_k + KW'(1);
            end
            if (w_load_hit || w_load_miss) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_qx <= i_in_data.coord_x;
            r_qy <= i_in_data.coord_y;
        end
        if (w_scan_rd) begin
            r_rd_idx <= r_issue[IW-1:0];
        end
        // strict less-than keeps the lowest index on ties
        if (dist_vld && (dist_val < w_bound)) begin
            r_best <= dist_val;
            r_sel  <= dist_idx;
        end
        if (r_state == ST_EMIT_RD) begin
            r_pad <= w_pad;
        end
        if (w_load_hit) begin
            r_out.found       <= 1'b1;
            r_out.ref_index   <= w_sel_ext[IXW-1:0];
            r_out.out_x       <= ram_rdata[ENTRY_W-1 -: XW];
            r_out.out_y       <= ram_rdata[HW +: XW];
            r_out.out_heading <= ram_rdata[HW-1:0];
            r_out.padded      <= r_pad;
            r_out.last        <= w_last_k;
        end else if (w_load_miss) begin
            r_out <= w_miss_beat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `ASSERT_PROP(a_len_bound, r_len <= LW'(ROUTE_DEPTH), "route length past depth")
    `ASSERT_PROP(a_load_free, (w_load_hit || w_load_miss) |-> w_out_free, "output overwritten")
    `ASSERT_PROP(a_pad_found, (o_out_valid && o_out_data.padded) |-> o_out_data.found, "padded miss")
    `ASSERT_NOT(a_read_past_end, w_scan_rd && (r_issue >= r_len), "scan read past route end")
    `ASSERT_PROP(a_query_scan, (w_accept && (i_in_data.op == OP_QUERY)) |=> (r_state == ST_SCAN), "query did not start scan")

endmodule
